[hdl/sfg_pkg.sv]
`default_nettype none
package sfg_pkg;

  typedef enum logic {
    MODE_SPRING = 1'b0,
    MODE_BUNGEE = 1'b1
  } mode_t;

  localparam logic [1:0] REG_SPRING_CONSTANT = 2'd0;
  localparam logic [1:0] REG_REST_LENGTH     = 2'd1;
  localparam logic [1:0] REG_MODE            = 2'd2;

endpackage
`default_nettype wire

[hdl/sfg_sqrt_cell.sv]
`default_nettype none
// One restoring step of the square root: tries one result bit and passes
// the partial root and the remainder on to the next cell.
module sfg_sqrt_cell #(
  parameter int SW  = 68,
  parameter int RW  = 34,
  parameter int BIT = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [SW-1:0] rad_i,
  input  wire logic [RW-1:0] root_i,
  output logic      [SW-1:0] rad_o,
  output logic      [RW-1:0] root_o
);
  logic [SW-1:0] trial;
  logic [SW-1:0] rad_nxt;
  logic [RW-1:0] root_nxt;
  logic [SW-1:0] rad_r;
  logic [RW-1:0] root_r;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    trial = (SW'(root_i) << (BIT + 1)) + (SW'(1) << (2 * BIT));
    if (rad_i >= trial) begin
      rad_nxt  = rad_i - trial;
      root_nxt = root_i | (RW'(1) << BIT);
    end else begin
      rad_nxt  = rad_i;
      root_nxt = root_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign root_o = root_r;
endmodule
`default_nettype wire

[hdl/sfg_div_cell.sv]
`default_nettype none
// One step of the unit-vector divider for both axes at once.
module sfg_div_cell #(
  parameter int MW    = 34,
  parameter int QW    = 17,
  parameter int SHIFT = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [MW:0]   remx_i,
  input  wire logic [MW:0]   remy_i,
  input  wire logic [QW-1:0] qx_i,
  input  wire logic [QW-1:0] qy_i,
  input  wire logic [MW-1:0] m_i,
  output logic      [MW:0]   remx_o,
  output logic      [MW:0]   remy_o,
  output logic      [QW-1:0] qx_o,
  output logic      [QW-1:0] qy_o
);
  logic [MW:0]   sx, sy;
  logic [MW:0]   remx_r, remy_r;
  logic [QW-1:0] qx_r, qy_r;

  // The integer step compares the dividend itself, the others double first.
  always_comb begin
    sx = (SHIFT != 0) ? (remx_i << 1) : remx_i;
    sy = (SHIFT != 0) ? (remy_i << 1) : remy_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sx >= {1'b0, m_i}) begin
        remx_r <= sx - {1'b0, m_i};
        qx_r   <= {qx_i[QW-2:0], 1'b1};
      end else begin
        remx_r <= sx;
        qx_r   <= {qx_i[QW-2:0], 1'b0};
      end
      if (sy >= {1'b0, m_i}) begin
        remy_r <= sy - {1'b0, m_i};
        qy_r   <= {qy_i[QW-2:0], 1'b1};
      end else begin
        remy_r <= sy;
        qy_r   <= {qy_i[QW-2:0], 1'b0};
      end
    end
  end

  assign remx_o = remx_r;
  assign remy_o = remy_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;
endmodule
`default_nettype wire

[hdl/spring_force_generator.sv]
`default_nettype none
// Channel | Ports            | Beat contents (low bit up)
// in      | in_t*            | particle_x, particle_y, other_x, other_y
// out     | out_t*           | force_x, force_y; tuser: applied, saturated
// cfg     | cfg_we/idx/wdata | 0 spring_constant, 1 rest_length, 2 mode
// One beat enters per cycle when not stalled; the pipeline is the chain of
// square-root cells and divider cells followed by the multipliers.
// The pipeline advances only when the output register can take a beat, and a
// valid bit travels with every stage. rst_n (synchronous) clears valid bits
// and loads the register reset values.
module spring_force_generator #(
  parameter int FRAC_BITS   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // particle_x, particle_y, other_x, other_y
  input  wire logic [4*VALUE_WIDTH-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // force_x, force_y
  output logic      [2*VALUE_WIDTH-1:0]   out_tdata,
  // applied, saturated
  output logic      [1:0]                 out_tuser,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_idx,
  input  wire logic [VALUE_WIDTH-1:0]     cfg_wdata
);
  localparam int W   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = W + 2;       // root width
  localparam int SW  = 2 * MW;      // squared-length width
  localparam int QW  = F + 2;       // unit part width
  localparam int NS  = MW;          // sqrt cells
  localparam int ND  = F + 1;       // div cells (first is the integer bit)
  localparam int GW  = 2 * W + 1;   // k*e width
  localparam int DEP = 2 + NS + ND + 2;

  logic [W-1:0] k_r, len_r;
  sfg_pkg::mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= W'(1) << F;
      len_r  <= '0;
      mode_r <= sfg_pkg::MODE_SPRING;
    end else if (cfg_we) begin
      case (cfg_idx)
        sfg_pkg::REG_SPRING_CONSTANT: k_r <= cfg_wdata;
        sfg_pkg::REG_REST_LENGTH:     len_r <= cfg_wdata;
        sfg_pkg::REG_MODE:            mode_r <= sfg_pkg::mode_t'(cfg_wdata[0]);
        default: ;
      endcase
    end
  end

  // Pipeline enable: stall everything when the output holds an untaken beat.
  logic adv;
  logic [DEP-1:0] v_r;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[DEP-2:0], in_tvalid};
  end

  // Sideband per stage: signs, zero flags and magnitudes of dx, dy.
  logic [DEP-1:0] sx_r, sy_r, zx_r, zy_r;
  logic [W:0] ax_r [DEP];
  logic [W:0] ay_r [DEP];

  // Stage 0: differences.
  logic signed [W:0] dx, dy;
  always_comb begin
    dx = $signed({in_tdata[W-1], in_tdata[W-1:0]})
       - $signed({in_tdata[3*W-1], in_tdata[3*W-1:2*W]});
    dy = $signed({in_tdata[2*W-1], in_tdata[2*W-1:W]})
       - $signed({in_tdata[4*W-1], in_tdata[4*W-1:3*W]});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r[0] <= dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
      ay_r[0] <= dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
      sx_r[0] <= dx[W];
      sy_r[0] <= dy[W];
      zx_r[0] <= (dx == '0);
      zy_r[0] <= (dy == '0);
      for (int i = 1; i < DEP; i++) begin
        ax_r[i] <= ax_r[i-1];
        ay_r[i] <= ay_r[i-1];
        sx_r[i] <= sx_r[i-1];
        sy_r[i] <= sy_r[i-1];
        zx_r[i] <= zx_r[i-1];
        zy_r[i] <= zy_r[i-1];
      end
    end
  end

  // Stage 1: squared length.
  logic [SW-1:0] sq_r;
  always_ff @(posedge clk) begin
    if (adv) sq_r <= SW'(ax_r[0]) * SW'(ax_r[0]) + SW'(ay_r[0]) * SW'(ay_r[0]);
  end

  // Square-root cells: stages 2 .. NS+1.
  logic [SW-1:0] rad [NS+1];
  logic [MW-1:0] root [NS+1];
  assign rad[0]  = sq_r;
  assign root[0] = '0;

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_sqrt
      sfg_sqrt_cell #(.SW(SW), .RW(MW), .BIT(NS - 1 - g)) u_cell (
        .clk   (clk),
        .en    (adv),
        .rad_i (rad[g]),
        .root_i(root[g]),
        .rad_o (rad[g+1]),
        .root_o(root[g+1])
      );
    end
  endgenerate

  // Divider cells carry the root alongside.
  localparam int D0 = NS + 2;
  logic [MW:0]   rx [ND+1];
  logic [MW:0]   ry [ND+1];
  logic [QW-1:0] qx [ND+1];
  logic [QW-1:0] qy [ND+1];
  logic [MW-1:0] mq_r [ND];
  // The first cell compares the magnitude with the root as it is.
  assign rx[0] = {1'b0, (MW)'(ax_r[D0-1])};
  assign ry[0] = {1'b0, (MW)'(ay_r[D0-1])};
  assign qx[0] = '0;
  assign qy[0] = '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      mq_r[0] <= root[NS];
      for (int i = 1; i < ND; i++) mq_r[i] <= mq_r[i-1];
    end
  end

  generate
    for (g = 0; g < ND; g++) begin : g_div
      logic [MW-1:0] mi;
      if (g == 0) begin : g_first
        assign mi = root[NS];
      end else begin : g_rest
        assign mi = mq_r[g-1];
      end
      sfg_div_cell #(.MW(MW), .QW(QW), .SHIFT((g == 0) ? 0 : 1)) u_cell (
        .clk   (clk),
        .en    (adv),
        .remx_i(rx[g]),
        .remy_i(ry[g]),
        .qx_i  (qx[g]),
        .qy_i  (qy[g]),
        .m_i   (mi),
        .remx_o(rx[g+1]),
        .remy_o(ry[g+1]),
        .qx_o  (qx[g+1]),
        .qy_o  (qy[g+1])
      );
    end
  endgenerate

  // Force magnitude: stage after dividers.
  localparam int E0 = D0 + ND;
  logic [MW-1:0] m_e;
  logic [MW:0]   ext;
  logic          slack;
  assign m_e = mq_r[ND-1];
  always_comb begin
    if ({1'b0, m_e} >= {3'b0, len_r}) ext = {1'b0, m_e} - (MW+1)'(len_r);
    else ext = (MW+1)'(len_r) - {1'b0, m_e};
    slack = (mode_r == sfg_pkg::MODE_BUNGEE) && ({1'b0, m_e} <= {3'b0, len_r});
  end

  logic [W+F:0] gmag_r;
  logic [QW-1:0] ux_r, uy_r;
  logic slack_r, mz_r;
  logic [W+MW:0] kprod;
  assign kprod = (W+MW+1)'(k_r) * (W+MW+1)'(ext[W:0]);
  logic [W+MW:0] kg;
  assign kg = kprod >> F;
  localparam logic [W+MW:0] CAP = (W+MW+1)'(1) << (W - 1 + F);

  always_ff @(posedge clk) begin
    if (adv) begin
      gmag_r  <= (kg > CAP) ? (W+F+1)'(CAP) : (W+F+1)'(kg);
      ux_r    <= qx[ND];
      uy_r    <= qy[ND];
      slack_r <= slack;
      mz_r    <= (m_e == '0);
    end
  end

  // Component products.
  logic [W+F+QW:0] cx_r, cy_r;
  logic slack2_r, mz2_r, nx_r, ny_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r <= ((W+F+QW+1)'(gmag_r) * (W+F+QW+1)'(ux_r)) >> F;
      cy_r <= ((W+F+QW+1)'(gmag_r) * (W+F+QW+1)'(uy_r)) >> F;
      slack2_r <= slack_r;
      mz2_r    <= mz_r;
      nx_r <= (mode_r == sfg_pkg::MODE_BUNGEE) ? sx_r[E0] : (!sx_r[E0] && !zx_r[E0]);
      ny_r <= (mode_r == sfg_pkg::MODE_BUNGEE) ? sy_r[E0] : (!sy_r[E0] && !zy_r[E0]);
    end
  end

  // Saturation and output register.
  logic [W-1:0] fx, fy;
  logic satx, saty;
  always_comb begin
    logic [W+F+QW:0] limx, limy;
    limx = ((W+F+QW+1)'(1) << (W - 1)) - (nx_r ? '0 : (W+F+QW+1)'(1));
    limy = ((W+F+QW+1)'(1) << (W - 1)) - (ny_r ? '0 : (W+F+QW+1)'(1));
    satx = cx_r > limx;
    saty = cy_r > limy;
    fx = satx ? W'(limx) : W'(cx_r);
    fy = saty ? W'(limy) : W'(cy_r);
    if (nx_r) fx = -fx;
    if (ny_r) fy = -fy;
    if (slack2_r || mz2_r) begin
      fx = '0;
      fy = '0;
      satx = 1'b0;
      saty = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= v_r[DEP-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {fy, fx};
      out_tuser <= {satx | saty, !slack2_r};
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
  a_slack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("slack result carries force");
`endif
endmodule
`default_nettype wire

[tb/spring_force_generator_test.sv]
`default_nettype none
module spring_force_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = 16;
  localparam int W = 32;
  localparam int DRAIN = W + F + 9 + 4;

  typedef struct packed {
    logic [W-1:0] fx;
    logic [W-1:0] fy;
    logic         applied;
    logic         sat;
  } force_t;

  typedef struct {
    sfg_pkg::mode_t md;
    logic [W-1:0]   px, py, ox, oy;
    logic           typed;
    force_t         res;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_we = 0;
  logic [4*W-1:0] in_tdata = '0;
  logic [1:0] cfg_idx = '0;
  logic [W-1:0] cfg_wdata = '0;
  logic out_tvalid;
  logic in_tready;
  logic [2*W-1:0] out_tdata;
  logic [1:0] out_tuser;

  logic [W-1:0] k_reg = 32'h0001_0000, len_reg = '0;
  sfg_pkg::mode_t mode_reg = sfg_pkg::MODE_SPRING;
  force_t pending_forces[$];
  int idle_pct = 33;
  int errors = 0;

  spring_force_generator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Signed component from magnitude g and unit part u, clamped to W bits.
  function automatic logic [W-1:0] scale_axis(logic [127:0] g, logic [127:0] u,
                                              logic neg, inout logic sat);
    logic [127:0] c, lim;
    c = (g * u) >> F;
    lim = (128'd1 << (W - 1)) - (neg ? 128'd0 : 128'd1);
    if (c > lim) begin
      c = lim;
      sat = 1'b1;
    end
    return neg ? W'(-c) : W'(c);
  endfunction

  function automatic force_t calc_force(logic [W-1:0] px, py, ox, oy);
    logic signed [W+1:0] dx, dy;
    logic [127:0] ax, ay, s, m, t, e, g, cap;
    logic sat;
    logic bungee;
    force_t r;
    r = '0;
    sat = 1'b0;
    bungee = (mode_reg == sfg_pkg::MODE_BUNGEE);
    dx = $signed({{2{px[W-1]}}, px}) - $signed({{2{ox[W-1]}}, ox});
    dy = $signed({{2{py[W-1]}}, py}) - $signed({{2{oy[W-1]}}, oy});
    ax = 128'($unsigned(dx[W+1] ? -dx : dx));
    ay = 128'($unsigned(dy[W+1] ? -dy : dy));
    s = ax * ax + ay * ay;
    m = '0;
    for (int b = W + 1; b >= 0; b--) begin
      t = m | (128'd1 << b);
      if (t * t <= s) m = t;
    end
    if (bungee) begin
      if (m <= len_reg) return r;
      e = m - len_reg;
    end else begin
      e = (m >= len_reg) ? m - len_reg : len_reg - m;
    end
    r.applied = 1'b1;
    if (m == 0) return r;
    g = (128'(k_reg) * e) >> F;
    cap = 128'd1 << (W - 1 + F);
    if (g > cap) g = cap;
    r.fx = scale_axis(g, (ax << F) / m, bungee ? dx[W+1] : (dx > 0), sat);
    r.fy = scale_axis(g, (ay << F) / m, bungee ? dy[W+1] : (dy > 0), sat);
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    force_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[W-1:0], out_tdata[2*W-1:W], out_tuser[0], out_tuser[1]};
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected beat fx=%h fy=%h user=%b", $realtime,
                 got.fx, got.fy, out_tuser);
        errors++;
      end else begin
        want = pending_forces.pop_front();
        if (got.fx !== want.fx)
          $display("%0t: force_x expected %h actual %h", $realtime, want.fx, got.fx);
        if (got.fy !== want.fy)
          $display("%0t: force_y expected %h actual %h", $realtime, want.fy, got.fy);
        if (got.applied !== want.applied)
          $display("%0t: applied expected %b actual %b", $realtime,
                   want.applied, got.applied);
        if (got.sat !== want.sat)
          $display("%0t: saturated expected %b actual %b", $realtime, want.sat, got.sat);
        if (got !== want) errors++;
      end
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sfg_pkg::REG_SPRING_CONSTANT: k_reg = val;
      sfg_pkg::REG_REST_LENGTH: len_reg = val;
      sfg_pkg::REG_MODE: mode_reg = sfg_pkg::mode_t'(val[0]);
      default: ;
    endcase
  endtask

  task automatic send_positions(logic [W-1:0] px, py, ox, oy,
                                logic typed, force_t res);
    force_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= {oy, ox, py, px};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    want = typed ? res : calc_force(px, py, ox, oy);
    pending_forces = {pending_forces, want};
  endtask

  function automatic logic [W-1:0] rand_pos();
    case ($urandom_range(4))
      0: return $urandom;
      1: return W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [W-1:0] rand_k();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 18);
      default: return $urandom_range(1 << 12, 1 << 17);
    endcase
  endfunction

  localparam logic [W-1:0] ONE = 32'h0001_0000;
  localparam logic [W-1:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [W-1:0] MINV = 32'h8000_0000;

  row_t rows[] = '{
    '{sfg_pkg::MODE_SPRING, '0, '0, '0, '0, 1'b1, '{'0, '0, 1'b1, 1'b0}},
    '{sfg_pkg::MODE_SPRING, ONE, '0, '0, '0, 1'b1, '{-ONE, '0, 1'b1, 1'b0}},
    '{sfg_pkg::MODE_SPRING, '0, ONE, '0, '0, 1'b1, '{'0, -ONE, 1'b1, 1'b0}},
    '{sfg_pkg::MODE_SPRING, MAXV, MAXV, MINV, MINV, 1'b1, '{MINV, MINV, 1'b1, 1'b1}},
    '{sfg_pkg::MODE_SPRING, MINV, MINV, MAXV, MAXV, 1'b1, '{MAXV, MAXV, 1'b1, 1'b1}},
    '{sfg_pkg::MODE_SPRING, MAXV, MINV, MINV, MAXV, 1'b0, '0},
    '{sfg_pkg::MODE_SPRING, 32'h0003_0000, 32'h0004_0000, '0, '0, 1'b0, '0},
    '{sfg_pkg::MODE_SPRING, 32'hFFFD_0000, 32'h0004_0000, 32'h1234, 32'h55, 1'b0, '0},
    '{sfg_pkg::MODE_SPRING, 32'd1, 32'd1, '0, '0, 1'b0, '0},
    '{sfg_pkg::MODE_SPRING, MAXV, '0, MAXV, '0, 1'b1, '{'0, '0, 1'b1, 1'b0}},
    '{sfg_pkg::MODE_BUNGEE, '0, '0, '0, '0, 1'b1, '{'0, '0, 1'b0, 1'b0}},
    '{sfg_pkg::MODE_BUNGEE, ONE, '0, '0, '0, 1'b1, '{'0, '0, 1'b0, 1'b0}},
    '{sfg_pkg::MODE_BUNGEE, 32'h0003_0000, 32'h0004_0000, '0, '0, 1'b0, '0},
    '{sfg_pkg::MODE_BUNGEE, MINV, MAXV, MAXV, MINV, 1'b0, '0},
    '{sfg_pkg::MODE_BUNGEE, MAXV, MAXV, MINV, MINV, 1'b1, '{MAXV, MAXV, 1'b1, 1'b1}},
    '{sfg_pkg::MODE_BUNGEE, 32'hFFF0_0000, 32'h0000_8000, '0, '0, 1'b0, '0}
  };

  initial begin
    logic [W-1:0] k_val, l_val;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Bungee rows run with a rest length of one so the unit offset is slack.
    foreach (rows[i]) begin
      if (rows[i].md != mode_reg) begin
        write_reg(sfg_pkg::REG_MODE, W'(rows[i].md));
        write_reg(sfg_pkg::REG_REST_LENGTH, ONE);
      end
      send_positions(rows[i].px, rows[i].py, rows[i].ox, rows[i].oy,
                     rows[i].typed, rows[i].res);
    end
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin k_val = '0; l_val = '0; end
        1: begin k_val = '1; l_val = '1; end
        2: begin k_val = ONE; l_val = '0; end
        default: begin
          k_val = rand_k();
          l_val = $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 22);
        end
      endcase
      write_reg(sfg_pkg::REG_SPRING_CONSTANT, k_val);
      write_reg(sfg_pkg::REG_REST_LENGTH, l_val);
      write_reg(sfg_pkg::REG_MODE, W'(ph % 2));
      // One phase runs both sides without any idle cycles.
      idle_pct = (ph == 2) ? 0 : 33;
      for (int n = 0; n < 200; n++)
        send_positions(rand_pos(), rand_pos(), rand_pos(), rand_pos(), 1'b0, '0);
    end
    idle_pct = 33;
    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
